### sv/tps_pkg.sv
// Shared types, constants and state encodings of the triangle plane splitter.
package tps_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int COORD_W         = 32;
    localparam int FIELDS          = 8;
    localparam int DIST_W          = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int RATIO_W         = COORD_FRAC_BITS + 1;
    localparam int STEP_W          = $clog2(COORD_FRAC_BITS + 1);
    localparam int SEQ_LEN         = 9;
    localparam int SEQ_IDX_W       = 4;
    localparam int QUEUE_DEPTH     = 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef coord_t [FIELDS-1:0] corner_t;
    typedef logic signed [DIST_W-1:0] dist_t;

    typedef struct packed {
        corner_t [2:0] corner;
        dist_t   [2:0] pdist;
    } tri_t;

    typedef struct packed {
        coord_t nx;
        coord_t ny;
        coord_t nz;
        coord_t off;
    } plane_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NORMAL_X = 3'd0,
        REG_NORMAL_Y = 3'd1,
        REG_NORMAL_Z = 3'd2,
        REG_OFFSET   = 3'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        SRC_C0 = 3'd0,
        SRC_C1 = 3'd1,
        SRC_C2 = 3'd2,
        SRC_P0 = 3'd3,
        SRC_P1 = 3'd4
    } src_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MAC,
        FR_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PREP,
        BK_DIV,
        BK_MUL,
        BK_ADD,
        BK_EMIT
    } back_state_t;

endpackage

### sv/triangle_plane_splitter.sv
// Front: a corner is accepted, its three products are formed and summed, and after the third
// corner its triangle is pushed; with the single distance multiplier, one corner is taken at a time.
// Back: a triangle on one side is popped and its 3 corners output; a cut triangle needs per edge
// point a setup step, COORD_FRAC_BITS division steps (none if the back corner lies on the plane)
// and a multiply and an add step per field; back and front overlap via a 2-deep queue.
// Reset (asynchronous, active low) empties the pipeline and loads the plane (0,0,1,0).
module triangle_plane_splitter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [tps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tps_pkg::COORD_W-1:0]  cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v
    input  logic [255:0]                 s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // out_x, out_y, out_z, out_nx, out_ny, out_nz, out_u, out_v
    output logic [255:0]                 m_axis_tdata,
    // side, triangle_end
    output logic [1:0]                   m_axis_tuser,
    output logic                         m_axis_tlast
);
    import tps_pkg::*;

    plane_t  plane_reg;
    tri_t    push_tri;
    tri_t    head;
    corner_t out_corner;
    logic    push;
    logic    pop;
    logic    queue_full;
    logic    queue_empty;
    logic    out_side;
    logic    out_tri_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg.nx  <= '0;
            plane_reg.ny  <= '0;
            plane_reg.nz  <= COORD_W'(1) << COORD_FRAC_BITS;
            plane_reg.off <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_NORMAL_X: plane_reg.nx  <= cfg_data;
                REG_NORMAL_Y: plane_reg.ny  <= cfg_data;
                REG_NORMAL_Z: plane_reg.nz  <= cfg_data;
                REG_OFFSET:   plane_reg.off <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    tps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .plane      (plane_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_corner  (s_axis_tdata),
        .push       (push),
        .push_tri   (push_tri),
        .queue_full (queue_full)
    );

    tps_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tri (push_tri),
        .full     (queue_full),
        .pop      (pop),
        .head     (head),
        .empty    (queue_empty)
    );

    tps_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_corner  (out_corner),
        .out_side    (out_side),
        .out_tri_end (out_tri_end),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = out_corner;
    assign m_axis_tuser = {out_tri_end, out_side};

endmodule

### sv/tps_front.sv
// Corner collection and plane distance computation; pushes whole triangles.
module tps_front (
    input  logic             clk,
    input  logic             rst_n,
    input  tps_pkg::plane_t  plane,
    input  logic             in_valid,
    output logic             in_ready,
    input  tps_pkg::corner_t in_corner,
    output logic             push,
    output tps_pkg::tri_t    push_tri,
    input  logic             queue_full
);
    import tps_pkg::*;

    front_state_t state_reg, state_next;
    logic [1:0]   slot_reg, slot_next;
    logic [1:0]   axis_reg;
    corner_t      corner_reg [3];
    dist_t        dist_reg [3];
    logic signed [2*COORD_W-1:0] prod_reg;
    dist_t        acc_reg;
    coord_t       n_sel;
    coord_t       p_sel;
    dist_t        acc_sum;

    always_comb
    begin
        case (axis_reg)
            2'd0:    n_sel = plane.nx;
            2'd1:    n_sel = plane.ny;
            default: n_sel = plane.nz;
        endcase
        p_sel   = corner_reg[slot_reg][{1'b0, axis_reg}];
        acc_sum = acc_reg + DIST_W'(prod_reg >>> COORD_FRAC_BITS);
    end

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        in_ready   = 1'b0;
        push       = 1'b0;
        case (state_reg)
            FR_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = FR_MAC;
                end
            end
            FR_MAC:
            begin
                if (axis_reg == 2'd3)
                begin
                    if (slot_reg == 2'd2)
                    begin
                        state_next = FR_PUSH;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 2'd1;
                        state_next = FR_IDLE;
                    end
                end
            end
            FR_PUSH:
            begin
                if (!queue_full)
                begin
                    push       = 1'b1;
                    slot_next  = 2'd0;
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
            slot_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

    // one product per cycle, accumulate the previous one
    always_ff @(posedge clk)
    begin
        if (state_reg == FR_IDLE && in_valid)
        begin
            corner_reg[slot_reg] <= in_corner;
            acc_reg              <= DIST_W'(plane.off);
            axis_reg             <= 2'd0;
        end
        else if (state_reg == FR_MAC)
        begin
            prod_reg <= n_sel * p_sel;
            axis_reg <= axis_reg + 2'd1;
            if (axis_reg != 2'd0)
            begin
                acc_reg <= acc_sum;
            end
            if (axis_reg == 2'd3)
            begin
                dist_reg[slot_reg] <= acc_sum;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            push_tri.corner[i] = corner_reg[i];
            push_tri.pdist[i]  = dist_reg[i];
        end
    end

endmodule

### sv/tps_queue.sv
// Two-entry triangle queue between the front and back parts.
module tps_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tps_pkg::tri_t push_tri,
    output logic          full,
    input  logic          pop,
    output tps_pkg::tri_t head,
    output logic          empty
);
    import tps_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    tri_t                 mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W:0]       count_reg;

    assign full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_tri;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (PTR_W+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (PTR_W+1)'(1);
            end
        end
    end

endmodule

### sv/tps_back.sv
// Triangle classification, edge point interpolation and output sequencing.
module tps_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             queue_empty,
    input  tps_pkg::tri_t    head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output tps_pkg::corner_t out_corner,
    output logic             out_side,
    output logic             out_tri_end,
    output logic             out_last
);
    import tps_pkg::*;

    back_state_t state_reg, state_next;
    tri_t        tri_reg;
    src_t        seq_reg [SEQ_LEN];
    logic [SEQ_IDX_W-1:0] split_reg;
    logic [SEQ_IDX_W-1:0] nout_reg;
    logic [SEQ_IDX_W-1:0] k_reg;
    logic [1:0]  tpos_reg;
    logic [1:0]  pf_reg [2];
    logic [1:0]  pb_reg [2];
    logic        pt_reg;
    corner_t     point_reg [2];
    logic [DIST_W-1:0] den_reg;
    logic [DIST_W-1:0] rem_reg;
    logic [RATIO_W-1:0] q_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [2:0]  field_reg;
    logic signed [COORD_W+RATIO_W+1:0] prod_reg;
    logic        out_valid_reg;
    corner_t     out_corner_reg;
    logic        out_side_reg;
    logic        out_tri_end_reg;
    logic        out_last_reg;

    // classification of the queue head
    logic [1:0]  nf;
    logic [1:0]  nb;
    logic [1:0]  fidx [2];
    logic [1:0]  bidx [2];
    logic        all_nonneg;
    logic        all_nonpos;
    src_t        cls_seq [SEQ_LEN];
    logic [SEQ_IDX_W-1:0] cls_split;
    logic [1:0]  cls_pf [2];
    logic [1:0]  cls_pb [2];

    always_comb
    begin
        nf         = 2'd0;
        nb         = 2'd0;
        fidx[0]    = 2'd0;
        fidx[1]    = 2'd0;
        bidx[0]    = 2'd0;
        bidx[1]    = 2'd0;
        all_nonneg = 1'b1;
        all_nonpos = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            if ($signed(head.pdist[i]) < 0)
            begin
                all_nonneg = 1'b0;
            end
            if ($signed(head.pdist[i]) > 0)
            begin
                all_nonpos    = 1'b0;
                fidx[nf[0]]   = 2'(i);
                nf            = nf + 2'd1;
            end
            else
            begin
                bidx[nb[0]]   = 2'(i);
                nb            = nb + 2'd1;
            end
        end
        for (int s = 0; s < SEQ_LEN; s++)
        begin
            cls_seq[s] = SRC_P1;
        end
        if (all_nonneg || all_nonpos)
        begin
            cls_seq[0] = SRC_C0;
            cls_seq[1] = SRC_C1;
            cls_seq[2] = SRC_C2;
            cls_split  = all_nonneg ? SEQ_IDX_W'(3) : SEQ_IDX_W'(0);
            cls_pf[0]  = fidx[0];
            cls_pf[1]  = fidx[0];
            cls_pb[0]  = bidx[0];
            cls_pb[1]  = bidx[1];
        end
        else if (nf == 2'd1)
        begin
            // one front corner: front triangle, then two back triangles
            cls_seq[0] = src_t'({1'b0, fidx[0]});
            cls_seq[1] = SRC_P0;
            cls_seq[2] = SRC_P1;
            cls_seq[3] = src_t'({1'b0, bidx[0]});
            cls_seq[4] = src_t'({1'b0, bidx[1]});
            cls_seq[5] = SRC_P0;
            cls_seq[6] = src_t'({1'b0, bidx[1]});
            cls_seq[7] = SRC_P0;
            cls_seq[8] = SRC_P1;
            cls_split  = SEQ_IDX_W'(3);
            cls_pf[0]  = fidx[0];
            cls_pf[1]  = fidx[0];
            cls_pb[0]  = bidx[0];
            cls_pb[1]  = bidx[1];
        end
        else
        begin
            // two front corners: two front triangles, then one back triangle
            cls_seq[0] = src_t'({1'b0, fidx[0]});
            cls_seq[1] = src_t'({1'b0, fidx[1]});
            cls_seq[2] = SRC_P0;
            cls_seq[3] = src_t'({1'b0, fidx[1]});
            cls_seq[4] = SRC_P0;
            cls_seq[5] = SRC_P1;
            cls_seq[6] = src_t'({1'b0, bidx[0]});
            cls_seq[7] = SRC_P0;
            cls_seq[8] = SRC_P1;
            cls_split  = SEQ_IDX_W'(6);
            cls_pf[0]  = fidx[0];
            cls_pf[1]  = fidx[1];
            cls_pb[0]  = bidx[0];
            cls_pb[1]  = bidx[0];
        end
    end

    // edge point datapath
    dist_t               df_sel;
    dist_t               db_sel;
    logic [DIST_W-1:0]   den_calc;
    logic [DIST_W-1:0]   rem_shift;
    coord_t              f_sel;
    coord_t              b_sel;
    logic signed [COORD_W:0] diff;
    logic signed [COORD_W+RATIO_W+1:0] prod_shift;
    logic                load_out;
    logic                emit_last;
    corner_t             src_corner;

    always_comb
    begin
        df_sel     = tri_reg.pdist[pf_reg[pt_reg]];
        db_sel     = tri_reg.pdist[pb_reg[pt_reg]];
        den_calc   = DIST_W'(df_sel - db_sel);
        rem_shift  = rem_reg << 1;
        f_sel      = tri_reg.corner[pf_reg[pt_reg]][field_reg];
        b_sel      = tri_reg.corner[pb_reg[pt_reg]][field_reg];
        diff       = (COORD_W+1)'(b_sel) - (COORD_W+1)'(f_sel);
        prod_shift = prod_reg >>> COORD_FRAC_BITS;
        load_out   = (state_reg == BK_EMIT) && (!out_valid_reg || out_ready);
        emit_last  = (k_reg == nout_reg - SEQ_IDX_W'(1));
        case (seq_reg[k_reg])
            SRC_C0:  src_corner = tri_reg.corner[0];
            SRC_C1:  src_corner = tri_reg.corner[1];
            SRC_C2:  src_corner = tri_reg.corner[2];
            SRC_P0:  src_corner = point_reg[0];
            default: src_corner = point_reg[1];
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    state_next = (all_nonneg || all_nonpos) ? BK_EMIT : BK_PREP;
                end
            end
            BK_PREP:
            begin
                state_next = (DIST_W'(df_sel) >= den_calc) ? BK_MUL : BK_DIV;
            end
            BK_DIV:
            begin
                if (step_reg == STEP_W'(COORD_FRAC_BITS - 1))
                begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                state_next = BK_ADD;
            end
            BK_ADD:
            begin
                if (field_reg == 3'(FIELDS - 1))
                begin
                    state_next = pt_reg ? BK_EMIT : BK_PREP;
                end
                else
                begin
                    state_next = BK_MUL;
                end
            end
            BK_EMIT:
            begin
                if (load_out && emit_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    tri_reg   <= head;
                    seq_reg   <= cls_seq;
                    split_reg <= cls_split;
                    nout_reg  <= (all_nonneg || all_nonpos) ? SEQ_IDX_W'(3)
                                                            : SEQ_IDX_W'(SEQ_LEN);
                    pf_reg    <= cls_pf;
                    pb_reg    <= cls_pb;
                    pt_reg    <= 1'b0;
                    k_reg     <= '0;
                    tpos_reg  <= 2'd0;
                end
            end
            BK_PREP:
            begin
                den_reg   <= den_calc;
                rem_reg   <= DIST_W'(df_sel);
                step_reg  <= '0;
                field_reg <= 3'd0;
                // back corner on the plane: the edge point is the back corner
                q_reg     <= (DIST_W'(df_sel) >= den_calc)
                             ? RATIO_W'(1) << COORD_FRAC_BITS : '0;
            end
            BK_DIV:
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (rem_shift >= den_reg)
                begin
                    rem_reg <= rem_shift - den_reg;
                    q_reg   <= {q_reg[RATIO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_shift;
                    q_reg   <= {q_reg[RATIO_W-2:0], 1'b0};
                end
            end
            BK_MUL:
            begin
                prod_reg <= diff * $signed({1'b0, q_reg});
            end
            BK_ADD:
            begin
                point_reg[pt_reg][field_reg] <= f_sel + prod_shift[COORD_W-1:0];
                field_reg                    <= field_reg + 3'd1;
                if (field_reg == 3'(FIELDS - 1))
                begin
                    pt_reg <= 1'b1;
                end
            end
            BK_EMIT:
            begin
                if (load_out)
                begin
                    out_corner_reg  <= src_corner;
                    out_side_reg    <= (k_reg >= split_reg);
                    out_tri_end_reg <= (tpos_reg == 2'd2);
                    out_last_reg    <= emit_last;
                    k_reg           <= k_reg + SEQ_IDX_W'(1);
                    tpos_reg        <= (tpos_reg == 2'd2) ? 2'd0 : tpos_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign out_corner  = out_corner_reg;
    assign out_side    = out_side_reg;
    assign out_tri_end = out_tri_end_reg;
    assign out_last    = out_last_reg;

endmodule
